>>> rtl/core/fcull_pkg.sv
// Shared types, widths and codes for the frustum cull test pipeline.
package fcull_pkg;

    // Number of clip planes held by the block and fixed-point fraction bits.
    localparam int PLANE_COUNT = 6;
    localparam int FRAC_BITS   = 16;

    // Field widths.
    localparam int Q_W    = 32;
    localparam int IDX_W  = 3;
    localparam int PROD_W = 2 * Q_W;
    // Three full products plus a scaled offset need two guard bits.
    localparam int ACC_W  = PROD_W + 2;

    localparam int LAST_PLANE = PLANE_COUNT - 1;

    typedef logic signed [Q_W-1:0]    t_q;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACC_W-1:0]  t_acc;

    localparam t_q Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
    localparam t_q Q_MAX = {1'b0, {(Q_W-1){1'b1}}};

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_SPHERE = 2'd1,
        ACT_DIST   = 2'd2,
        ACT_BOX    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CLS_IN   = 2'd0,
        CLS_PART = 2'd1,
        CLS_OUT  = 2'd2
    } t_class;

    // Load enables for the per-plane datapath stages.
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_stage_en;

endpackage

>>> rtl/core/fcull_planes.sv
// Clip plane register file: normals and offsets, written by load words.
module fcull_planes import fcull_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_idx,
    input  t_q               i_nx,
    input  t_q               i_ny,
    input  t_q               i_nz,
    input  t_q               i_ofs,
    output t_q               o_nrm [PLANE_COUNT][3],
    output t_q               o_ofs [PLANE_COUNT]
);

    t_q r_nrm [PLANE_COUNT][3];
    t_q r_ofs [PLANE_COUNT];

    // Reset leaves the cleared frustum: plane 0 has an infinite negative offset.
    // A load to an index beyond the plane count matches no entry and is dropped.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < PLANE_COUNT; i++) begin
            if (!i_rst_n) begin
                r_nrm[i][0] <= '0;
                r_nrm[i][1] <= '0;
                r_nrm[i][2] <= '0;
                r_ofs[i]    <= (i == 0) ? Q_MIN : t_q'(0);
            end else if (i_wr_en && (int'(i_wr_idx) == i)) begin
                r_nrm[i][0] <= i_nx;
                r_nrm[i][1] <= i_ny;
                r_nrm[i][2] <= i_nz;
                r_ofs[i]    <= i_ofs;
            end
        end
    end

    assign o_nrm = r_nrm;
    assign o_ofs = r_ofs;

endmodule

>>> rtl/core/fcull_lane.sv
// Datapath for one clip plane: products, min/max selection and exact sums.
module fcull_lane import fcull_pkg::*; (
    input  logic      i_clk,
    input  t_stage_en i_en,
    input  logic      i_box,
    input  t_q        i_pos [3],
    input  t_q        i_far [3],
    input  t_q        i_nrm [3],
    input  t_q        i_ofs,
    output t_acc      o_hi_sum,
    output t_acc      o_lo_sum,
    output logic      o_inf
);

    t_prod r_pa [3];
    t_prod r_pb [3];
    t_acc  r_ofs2;
    logic  r_inf2;

    t_prod r_hi [3];
    t_prod r_lo [3];
    t_acc  r_ofs3;
    logic  r_inf3;

    t_acc  r_hp;
    t_acc  r_hq;
    t_acc  r_lp;
    t_acc  r_lq;
    logic  r_inf4;

    t_acc  r_hs;
    t_acc  r_ls;
    logic  r_inf5;

    // Stage 2: full-width products of the normal with both corners.
    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            for (int k = 0; k < 3; k++) begin
                r_pa[k] <= i_pos[k] * i_nrm[k];
                r_pb[k] <= i_far[k] * i_nrm[k];
            end
            r_ofs2 <= t_acc'(i_ofs) <<< FRAC_BITS;
            r_inf2 <= (i_ofs == Q_MIN);
        end
    end

    // Stage 3: larger and smaller product per axis; a sphere uses its centre only.
    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            for (int k = 0; k < 3; k++) begin
                if (r_pa[k] > r_pb[k]) begin
                    r_hi[k] <= r_pa[k];
                    r_lo[k] <= r_pb[k];
                end else begin
                    r_hi[k] <= i_box ? r_pb[k] : r_pa[k];
                    r_lo[k] <= r_pa[k];
                end
            end
            r_ofs3 <= r_ofs2;
            r_inf3 <= r_inf2;
        end
    end

    // Stage 4: pairwise partial sums.
    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_hp   <= t_acc'(r_hi[0]) + t_acc'(r_hi[1]);
            r_hq   <= t_acc'(r_hi[2]) + r_ofs3;
            r_lp   <= t_acc'(r_lo[0]) + t_acc'(r_lo[1]);
            r_lq   <= t_acc'(r_lo[2]) + r_ofs3;
            r_inf4 <= r_inf3;
        end
    end

    // Stage 5: exact plane distances.
    always_ff @(posedge i_clk) begin
        if (i_en.s5) begin
            r_hs   <= r_hp + r_hq;
            r_ls   <= r_lp + r_lq;
            r_inf5 <= r_inf4;
        end
    end

    assign o_hi_sum = r_hs;
    assign o_lo_sum = r_ls;
    assign o_inf    = r_inf5;

endmodule

>>> rtl/core/frustum_cull_test.sv
// Frustum cull test top level: input stage, plane lanes and result stage.
//
// Usage: the input channel (i_valid, o_stall) carries one word per item. A
// load word (action 0) writes the plane given by i_plane_index and gives no
// result; a load to an index past the last plane is dropped. Sphere, distance
// and box test words each give one result word on the output channel
// (o_valid, i_stall) with o_cull_class and o_near_distance.
// A test word passes the input register, lane stages 2 to 5 and the output
// register before it appears at o_valid. Throughput is one word per cycle
// when nothing stalls; the limit is the six-stage pipeline with all plane
// lanes working in parallel, each lane built around its own 32x32 multipliers.
// A load takes effect for every test word accepted after it.
// Reset clears all planes to zero except plane 0, whose offset is set to
// negative infinity, so every test rejects until planes are loaded; all
// pipeline valid bits are cleared.
// When the receiver stalls, the result holds on the outputs and empty
// stages keep filling; o_stall rises only when every stage holds a word.
module frustum_cull_test import fcull_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [1:0]       i_action,
    input  logic [IDX_W-1:0] i_plane_index,
    input  t_q               i_pos_x,
    input  t_q               i_pos_y,
    input  t_q               i_pos_z,
    input  t_q               i_far_x,
    input  t_q               i_far_y,
    input  t_q               i_far_z,
    input  t_q               i_radius,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [1:0]       o_cull_class,
    output t_q               o_near_distance
);

    // Stage valid bits and payload.
    logic    r_v1, r_v2, r_v3, r_v4, r_v5, r_ov;
    t_action r_act1, r_act2, r_act3, r_act4, r_act5;
    t_q      r_pos1 [3];
    t_q      r_far1 [3];
    t_q      r_rad1;
    t_acc    r_thr2, r_thr3, r_thr4, r_thr5;
    t_class  r_cls;
    t_q      r_nd;

    logic      w_en1, w_en_out, w_accept;
    t_stage_en w_en;
    t_action   w_act_in;

    t_q   w_nrm [PLANE_COUNT][3];
    t_q   w_ofs [PLANE_COUNT];
    t_acc w_hs  [PLANE_COUNT];
    t_acc w_ls  [PLANE_COUNT];
    logic [PLANE_COUNT-1:0] w_inf;

    t_class n_cls;
    t_q     n_nd;

    // Each stage loads when it is empty or the stage after it moves on.
    assign w_en_out = !r_ov || !i_stall;
    assign w_en.s5  = !r_v5 || w_en_out;
    assign w_en.s4  = !r_v4 || w_en.s5;
    assign w_en.s3  = !r_v3 || w_en.s4;
    assign w_en.s2  = !r_v2 || w_en.s3;
    assign w_en1    = !r_v1 || w_en.s2;
    assign o_stall  = !w_en1;
    assign w_accept = i_valid && w_en1;
    assign w_act_in = t_action'(i_action);

    // Valid bits; load words do not enter the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_en1)    r_v1 <= w_accept && (w_act_in != ACT_LOAD);
            if (w_en.s2)  r_v2 <= r_v1;
            if (w_en.s3)  r_v3 <= r_v2;
            if (w_en.s4)  r_v4 <= r_v3;
            if (w_en.s5)  r_v5 <= r_v4;
            if (w_en_out) r_ov <= r_v5;
        end
    end

    // Input registers.
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_act1    <= w_act_in;
            r_pos1[0] <= i_pos_x;
            r_pos1[1] <= i_pos_y;
            r_pos1[2] <= i_pos_z;
            r_far1[0] <= i_far_x;
            r_far1[1] <= i_far_y;
            r_far1[2] <= i_far_z;
            r_rad1    <= i_radius;
        end
    end

    // Sphere threshold -radius at full accumulator scale, carried with the word.
    always_ff @(posedge i_clk) begin
        if (w_en.s2) begin
            r_act2 <= r_act1;
            r_thr2 <= (-t_acc'(r_rad1)) <<< FRAC_BITS;
        end
        if (w_en.s3) begin
            r_act3 <= r_act2;
            r_thr3 <= r_thr2;
        end
        if (w_en.s4) begin
            r_act4 <= r_act3;
            r_thr4 <= r_thr3;
        end
        if (w_en.s5) begin
            r_act5 <= r_act4;
            r_thr5 <= r_thr4;
        end
    end

    fcull_planes u_planes (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (w_accept && (w_act_in == ACT_LOAD)),
        .i_wr_idx (i_plane_index),
        .i_nx     (i_pos_x),
        .i_ny     (i_pos_y),
        .i_nz     (i_pos_z),
        .i_ofs    (i_radius),
        .o_nrm    (w_nrm),
        .o_ofs    (w_ofs)
    );

    // One lane per clip plane.
    for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_lane
        fcull_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_box    (r_act2 == ACT_BOX),
            .i_pos    (r_pos1),
            .i_far    (r_far1),
            .i_nrm    (w_nrm[g]),
            .i_ofs    (w_ofs[g]),
            .o_hi_sum (w_hs[g]),
            .o_lo_sum (w_ls[g]),
            .o_inf    (w_inf[g])
        );
    end

    // Result: per-plane compares, reduction over planes and distance saturation.
    always_comb begin
        logic [PLANE_COUNT-1:0] rej_le;
        logic [PLANE_COUNT-1:0] box_out;
        logic [PLANE_COUNT-1:0] box_part;
        t_acc                   shifted;

        for (int i = 0; i < PLANE_COUNT; i++) begin
            rej_le[i]   = w_inf[i] || (w_hs[i] <= r_thr5);
            box_out[i]  = w_inf[i] || (w_hs[i] < t_acc'(0));
            box_part[i] = (w_ls[i] < t_acc'(0));
        end
        shifted = w_hs[LAST_PLANE] >>> FRAC_BITS;

        n_cls = CLS_IN;
        n_nd  = '0;
        case (r_act5)
            ACT_SPHERE: begin
                n_cls = (|rej_le) ? CLS_OUT : CLS_IN;
            end
            ACT_DIST: begin
                if (|rej_le[LAST_PLANE-1:0]) begin
                    n_cls = CLS_OUT;
                end else if (w_inf[LAST_PLANE]) begin
                    n_cls = CLS_OUT;
                    n_nd  = Q_MIN;
                end else begin
                    n_cls = (w_hs[LAST_PLANE] < r_thr5) ? CLS_OUT : CLS_IN;
                    if (shifted > t_acc'(Q_MAX)) begin
                        n_nd = Q_MAX;
                    end else if (shifted < t_acc'(Q_MIN)) begin
                        n_nd = Q_MIN;
                    end else begin
                        n_nd = shifted[Q_W-1:0];
                    end
                end
            end
            ACT_BOX: begin
                if (|box_out) begin
                    n_cls = CLS_OUT;
                end else if (|box_part) begin
                    n_cls = CLS_PART;
                end else begin
                    n_cls = CLS_IN;
                end
            end
            default: begin
                n_cls = CLS_IN;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (w_en_out) begin
            r_cls <= n_cls;
            r_nd  <= n_nd;
        end
    end

    assign o_valid         = r_ov;
    assign o_cull_class    = r_cls;
    assign o_near_distance = r_nd;

endmodule
